// ----- src/fast_pkg.sv -----
// shared types and constants for the frame ack sequence tracker
// used by fast_front, fast_queue, fast_back and frame_ack_sequence_tracker
package fast_pkg;

  localparam int unsigned QDEPTH   = 2;
  localparam int unsigned QPTR_W   = $clog2(QDEPTH);
  localparam int unsigned S_DATA_W = 136;
  localparam int unsigned M_DATA_W = 72;
  localparam int unsigned APB_AW   = 4;

  localparam logic [31:0] MAGIC_RST    = 32'd0;
  localparam logic [15:0] VERSION_RST  = 16'd0;
  localparam logic [15:0] MAX_ROWS_RST = 16'd64;
  localparam logic [7:0]  BUDGET_RST   = 8'd32;

  typedef enum logic {
    KIND_CMD   = 1'b0,
    KIND_FRAME = 1'b1
  } kind_e;

  typedef enum logic [2:0] {
    ST_PUBLISHED   = 3'd0,
    ST_DUPLICATE   = 3'd1,
    ST_MAGIC_ERR   = 3'd2,
    ST_VERSION_ERR = 3'd3,
    ST_SIZE_ERR    = 3'd4,
    ST_CRC_ERR     = 3'd5,
    ST_CMD_QUEUED  = 3'd6
  } status_e;

  typedef enum logic [1:0] {
    EV_NONE   = 2'd0,
    EV_ACKED  = 2'd1,
    EV_NACKED = 2'd2,
    EV_GAVEUP = 2'd3
  } event_e;

  typedef enum logic [1:0] {
    REG_MAGIC    = 2'd0,
    REG_VERSION  = 2'd1,
    REG_MAX_ROWS = 2'd2,
    REG_BUDGET   = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic [31:0] magic;
    logic [15:0] version;
    logic [15:0] max_rows;
    logic [7:0]  budget;
  } cfg_t;

  typedef struct packed {
    kind_e       kind;
    logic        pre_ok;
    status_e     pre_status;
    logic [15:0] cmd_rows;
    logic [15:0] rows;
    logic [31:0] seq;
    logic [15:0] ack;
    logic        ack_ok;
    logic        nack;
    logic        applied;
    logic        crc_good;
  } entry_t;

  typedef struct packed {
    status_e     status;
    logic [30:0] gap;
    logic        seq_reset;
    event_e      cmd_event;
    logic        busy;
    logic [15:0] cmd_number;
    logic [15:0] locked_rows;
  } result_t;

endpackage

// ----- src/fast_front.sv -----
// input side: accepts words, unpacks them and runs the header checks that need only config
// depends on fast_pkg
module fast_front
  import fast_pkg::*;
(
  input  logic                s_valid_i,
  input  logic                s_user_i,
  input  logic [S_DATA_W-1:0] s_data_i,
  output logic                s_ready_o,
  input  cfg_t                cfg_i,
  input  logic                q_full_i,
  output logic                push_o,
  output entry_t              entry_o
);

  logic [15:0] rows;
  logic [31:0] magic;
  logic [15:0] version;

  assign s_ready_o = ~q_full_i;
  assign push_o    = s_valid_i & ~q_full_i;

  assign magic   = s_data_i[47:16];
  assign version = s_data_i[63:48];
  assign rows    = s_data_i[79:64];

  always_comb begin
    entry_o            = '0;
    entry_o.kind       = kind_e'(s_user_i);
    entry_o.cmd_rows   = s_data_i[15:0];
    entry_o.rows       = rows;
    entry_o.seq        = s_data_i[111:80];
    entry_o.ack        = s_data_i[127:112];
    entry_o.ack_ok     = s_data_i[128];
    entry_o.nack       = s_data_i[129];
    entry_o.applied    = s_data_i[130];
    entry_o.crc_good   = s_data_i[131];
    entry_o.pre_ok     = 1'b0;
    entry_o.pre_status = ST_PUBLISHED;
    if (magic != cfg_i.magic) begin
      entry_o.pre_status = ST_MAGIC_ERR;
    end else if (version != cfg_i.version) begin
      entry_o.pre_status = ST_VERSION_ERR;
    end else if (rows == 16'd0 || rows > cfg_i.max_rows) begin
      entry_o.pre_status = ST_SIZE_ERR;
    end else begin
      entry_o.pre_ok = 1'b1;
    end
  end

endmodule

// ----- src/fast_queue.sv -----
// short queue between the front and the back, two entries of fast_pkg::entry_t
// depends on fast_pkg
module fast_queue
  import fast_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  entry_t entry_i,
  input  logic   pop_i,
  output entry_t entry_o,
  output logic   full_o,
  output logic   empty_o
);

  entry_t            mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [QPTR_W:0]   cnt_q, cnt_d;

  assign full_o  = (cnt_q == (QPTR_W+1)'(QDEPTH));
  assign empty_o = (cnt_q == '0);
  assign entry_o = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == QPTR_W'(QDEPTH-1)) ? '0 : wr_q + QPTR_W'(1);
    end
    if (pop_i) begin
      rd_d = (rd_q == QPTR_W'(QDEPTH-1)) ? '0 : rd_q + QPTR_W'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + (QPTR_W+1)'(1);
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - (QPTR_W+1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= entry_i;
    end
  end

endmodule

// ----- src/fast_back.sv -----
// back side: lock check, command retry/ack machine, sequence tracking and result register
// depends on fast_pkg
module fast_back
  import fast_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    q_empty_i,
  input  entry_t  entry_i,
  output logic    pop_o,
  input  logic [7:0] budget_i,
  output logic    m_valid_o,
  input  logic    m_ready_i,
  output result_t result_o
);

  logic        busy_q, busy_d;
  logic [15:0] counter_q, counter_d;
  logic [7:0]  retries_q, retries_d;
  logic [15:0] req_rows_q, req_rows_d;
  logic [15:0] active_q, active_d;
  logic        seen_q, seen_d;
  logic [31:0] prev_q, prev_d;
  logic        out_valid_q;
  result_t     out_q, out_d;
  logic [31:0] diff;

  assign pop_o     = ~q_empty_i & (~out_valid_q | m_ready_i);
  assign m_valid_o = out_valid_q;
  assign result_o  = out_q;
  assign diff      = entry_i.seq - prev_q;

  always_comb begin
    busy_d         = busy_q;
    counter_d      = counter_q;
    retries_d      = retries_q;
    req_rows_d     = req_rows_q;
    active_d       = active_q;
    seen_d         = seen_q;
    prev_d         = prev_q;
    out_d          = '0;
    out_d.status   = ST_PUBLISHED;
    out_d.cmd_event = EV_NONE;
    if (entry_i.kind == KIND_CMD) begin
      counter_d    = counter_q + 16'd1;
      req_rows_d   = entry_i.cmd_rows;
      busy_d       = 1'b1;
      retries_d    = budget_i;
      out_d.status = ST_CMD_QUEUED;
    end else begin
      if (busy_q && retries_q != 8'd0) begin
        retries_d = retries_q - 8'd1;
      end
      if (!entry_i.pre_ok) begin
        out_d.status = entry_i.pre_status;
      end else if (active_q != 16'd0 && entry_i.rows != active_q && !entry_i.applied) begin
        out_d.status = ST_SIZE_ERR;
      end else if (!entry_i.crc_good) begin
        out_d.status = ST_CRC_ERR;
      end else begin
        // command machine
        if (busy_q) begin
          if (entry_i.ack != counter_q) begin
            if (retries_d == 8'd0) begin
              busy_d          = 1'b0;
              out_d.cmd_event = EV_GAVEUP;
            end
          end else if (entry_i.ack_ok) begin
            active_d        = req_rows_q;
            busy_d          = 1'b0;
            out_d.cmd_event = EV_ACKED;
          end else if (entry_i.nack) begin
            busy_d          = 1'b0;
            out_d.cmd_event = EV_NACKED;
          end
        end
        // sequence tracking
        if (!seen_q) begin
          seen_d = 1'b1;
          prev_d = entry_i.seq;
        end else if (diff == 32'd0) begin
          out_d.status = ST_DUPLICATE;
        end else begin
          prev_d = entry_i.seq;
          if (diff[31]) begin
            out_d.seq_reset = 1'b1;
          end else if (diff != 32'd1) begin
            out_d.gap = 31'(diff - 32'd1);
          end
        end
      end
    end
    out_d.busy        = busy_d;
    out_d.cmd_number  = counter_d;
    out_d.locked_rows = active_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      counter_q   <= '0;
      retries_q   <= '0;
      req_rows_q  <= '0;
      active_q    <= '0;
      seen_q      <= 1'b0;
      prev_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        busy_q     <= busy_d;
        counter_q  <= counter_d;
        retries_q  <= retries_d;
        req_rows_q <= req_rows_d;
        active_q   <= active_d;
        seen_q     <= seen_d;
        prev_q     <= prev_d;
      end
      if (pop_o) begin
        out_valid_q <= 1'b1;
      end else if (m_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_q <= out_d;
    end
  end

endmodule

// ----- src/frame_ack_sequence_tracker.sv -----
// top level of the frame ack sequence tracker: config registers, front, queue and back
// depends on fast_pkg, fast_front, fast_queue, fast_back
//
// channel   direction  contents
// s_axis    in         tuser: op; tdata: cmd_block_rows .. crc_good
// m_axis    out        tuser: frame_status; tdata: gap_count .. locked_rows
// apb       in/out     expected_magic, expected_version, max_rows, retry_budget
//
// one word per cycle sustained while m_axis_tready is high; a result is registered
// (combinational front check into a queue slot, then back update into the output register)
// while a result waits the two-entry queue takes two more words, then s_axis_tready drops
// reset clears tracker and queue state, sets config to its reset values; no clearing pass
module frame_ack_sequence_tracker
  import fast_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic                s_axis_tuser,  // op
  // cmd_block_rows[15:0] hdr_magic[47:16] hdr_version[63:48] hdr_rows[79:64]
  // hdr_seq[111:80] ack_seq[127:112] ack_ok_bit[128] nack_bit[129] applied_bit[130]
  // crc_good[131] zero[135:132]
  input  logic [S_DATA_W-1:0] s_axis_tdata,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [2:0]          m_axis_tuser,  // frame_status
  // gap_count[30:0] seq_reset[31] cmd_event[33:32] cmd_busy[34] cmd_number[50:35]
  // locked_rows[66:51] zero[71:67]
  output logic [M_DATA_W-1:0] m_axis_tdata,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [APB_AW-1:0]   paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  cfg_t     cfg_q;
  reg_idx_e reg_idx;
  logic     q_full, q_empty, push, pop;
  entry_t   entry_in, entry_out;
  result_t  result;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.magic    <= MAGIC_RST;
      cfg_q.version  <= VERSION_RST;
      cfg_q.max_rows <= MAX_ROWS_RST;
      cfg_q.budget   <= BUDGET_RST;
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_idx)
        REG_MAGIC:    cfg_q.magic    <= pwdata;
        REG_VERSION:  cfg_q.version  <= pwdata[15:0];
        REG_MAX_ROWS: cfg_q.max_rows <= pwdata[15:0];
        REG_BUDGET:   cfg_q.budget   <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_MAGIC:    prdata = cfg_q.magic;
      REG_VERSION:  prdata = {16'd0, cfg_q.version};
      REG_MAX_ROWS: prdata = {16'd0, cfg_q.max_rows};
      REG_BUDGET:   prdata = {24'd0, cfg_q.budget};
      default:      prdata = '0;
    endcase
  end

  fast_front u_front (
    .s_valid_i (s_axis_tvalid),
    .s_user_i  (s_axis_tuser),
    .s_data_i  (s_axis_tdata),
    .s_ready_o (s_axis_tready),
    .cfg_i     (cfg_q),
    .q_full_i  (q_full),
    .push_o    (push),
    .entry_o   (entry_in)
  );

  fast_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (entry_in),
    .pop_i   (pop),
    .entry_o (entry_out),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  fast_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_empty_i (q_empty),
    .entry_i   (entry_out),
    .pop_o     (pop),
    .budget_i  (cfg_q.budget),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .result_o  (result)
  );

  assign m_axis_tuser = result.status;
  assign m_axis_tdata = {5'd0, result.locked_rows, result.cmd_number, result.busy,
                         result.cmd_event, result.seq_reset, result.gap};

endmodule

// ----- tb/frame_ack_sequence_tracker_tb.sv -----
// testbench for frame_ack_sequence_tracker: random and directed words with stream stalls
// predicts every result in a scoreboard class; needs fast_pkg and the tracker rtl
`timescale 1ns / 1ps

module frame_ack_sequence_tracker_tb;
  import fast_pkg::*;

  localparam int unsigned STALL_LIMIT = 2000;

  typedef struct packed {
    logic [3:0]  pad;
    logic        crc_good;
    logic        applied;
    logic        nack;
    logic        ack_ok;
    logic [15:0] ack_seq;
    logic [31:0] seq;
    logic [15:0] rows;
    logic [15:0] version;
    logic [31:0] magic;
    logic [15:0] cmd_rows;
  } word_in_t;

  typedef struct packed {
    logic [4:0]  pad;
    logic [15:0] locked_rows;
    logic [15:0] cmd_number;
    logic        busy;
    logic [1:0]  cmd_event;
    logic        seq_reset;
    logic [30:0] gap;
  } word_out_t;

  class tracker_scoreboard;
    logic [31:0] magic;
    logic [15:0] version;
    logic [15:0] max_rows;
    logic [7:0]  budget;
    bit          busy;
    bit          seen;
    logic [15:0] cmd_cnt;
    logic [15:0] req_rows;
    logic [15:0] lock_rows;
    logic [7:0]  retries;
    logic [31:0] prev_seq;
    result_t     due_results[$];
    int          errors;

    function new();
      magic     = MAGIC_RST;
      version   = VERSION_RST;
      max_rows  = MAX_ROWS_RST;
      budget    = BUDGET_RST;
      busy      = 1'b0;
      seen      = 1'b0;
      cmd_cnt   = '0;
      req_rows  = '0;
      lock_rows = '0;
      retries   = '0;
      prev_seq  = '0;
      errors    = 0;
    endfunction

    function void set_reg(reg_idx_e idx, logic [31:0] value);
      case (idx)
        REG_MAGIC:    magic = value;
        REG_VERSION:  version = value[15:0];
        REG_MAX_ROWS: max_rows = value[15:0];
        REG_BUDGET:   budget = value[7:0];
      endcase
    endfunction

    function void due(status_e st, logic [30:0] gap, logic wrapped, event_e ev);
      result_t r;
      r.status      = st;
      r.gap         = gap;
      r.seq_reset   = wrapped;
      r.cmd_event   = ev;
      r.busy        = busy;
      r.cmd_number  = cmd_cnt;
      r.locked_rows = lock_rows;
      due_results.push_back(r);
    endfunction

    function void absorb_word(kind_e kind, word_in_t w);
      event_e      ev;
      logic [31:0] diff;
      ev = EV_NONE;
      if (kind == KIND_CMD) begin
        cmd_cnt  = cmd_cnt + 16'd1;
        req_rows = w.cmd_rows;
        busy     = 1'b1;
        retries  = budget;
        due(ST_CMD_QUEUED, '0, 1'b0, EV_NONE);
        return;
      end
      if (busy && retries != 0) retries = retries - 8'd1;
      if (w.magic != magic) begin
        due(ST_MAGIC_ERR, '0, 1'b0, EV_NONE);
      end else if (w.version != version) begin
        due(ST_VERSION_ERR, '0, 1'b0, EV_NONE);
      end else if (w.rows == 0 || w.rows > max_rows) begin
        due(ST_SIZE_ERR, '0, 1'b0, EV_NONE);
      end else if (lock_rows != 0 && w.rows != lock_rows && !w.applied) begin
        due(ST_SIZE_ERR, '0, 1'b0, EV_NONE);
      end else if (!w.crc_good) begin
        due(ST_CRC_ERR, '0, 1'b0, EV_NONE);
      end else begin
        if (busy) begin
          if (w.ack_seq != cmd_cnt) begin
            if (retries == 0) begin
              busy = 1'b0;
              ev = EV_GAVEUP;
            end
          end else if (w.ack_ok) begin
            lock_rows = req_rows;
            busy = 1'b0;
            ev = EV_ACKED;
          end else if (w.nack) begin
            busy = 1'b0;
            ev = EV_NACKED;
          end
        end
        if (!seen) begin
          seen = 1'b1;
          prev_seq = w.seq;
          due(ST_PUBLISHED, '0, 1'b0, ev);
        end else begin
          diff = w.seq - prev_seq;
          if (diff == 0) begin
            due(ST_DUPLICATE, '0, 1'b0, ev);
          end else begin
            prev_seq = w.seq;
            if (diff < 32'h8000_0000) due(ST_PUBLISHED, 31'(diff - 32'd1), 1'b0, ev);
            else due(ST_PUBLISHED, '0, 1'b1, ev);
          end
        end
      end
    endfunction

    function void compare(string field, logic [31:0] exp_v, logic [31:0] act_v);
      if (exp_v !== act_v) begin
        errors++;
        $display("%0t: %s expected %0h actual %0h", $time, field, exp_v, act_v);
      end
    endfunction

    function void check_result(logic [2:0] status, word_out_t w);
      result_t e;
      if (due_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected word, expected none actual status %0d tdata %h",
                 $time, status, w);
        return;
      end
      e = due_results.pop_front();
      compare("frame_status", 32'(e.status), 32'(status));
      compare("gap_count", 32'(e.gap), 32'(w.gap));
      compare("seq_reset", 32'(e.seq_reset), 32'(w.seq_reset));
      compare("cmd_event", 32'(e.cmd_event), 32'(w.cmd_event));
      compare("cmd_busy", 32'(e.busy), 32'(w.busy));
      compare("cmd_number", 32'(e.cmd_number), 32'(w.cmd_number));
      compare("locked_rows", 32'(e.locked_rows), 32'(w.locked_rows));
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic                s_axis_tuser = 1'b0;
  logic [S_DATA_W-1:0] s_axis_tdata = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [2:0]          m_axis_tuser;
  logic [M_DATA_W-1:0] m_axis_tdata;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [APB_AW-1:0]   paddr = '0;
  logic [31:0]         pwdata = '0;
  logic [31:0]         prdata;
  logic                pready;

  bit                  no_idle = 1'b0;
  tracker_scoreboard   sb = new();

  frame_ack_sequence_tracker u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  always @(negedge clk_i) begin
    m_axis_tready <= no_idle || ($urandom_range(99) >= 24);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) sb.absorb_word(kind_e'(s_axis_tuser), s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tuser, m_axis_tdata);
    end
  end

  initial begin : watchdog
    int unsigned stall_cycles;
    stall_cycles = 0;
    while (stall_cycles < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) stall_cycles = 0;
      else stall_cycles++;
    end
    $display("frame_ack_sequence_tracker_tb NOT OK");
    $finish;
  end

  task automatic push_word(kind_e kind, word_in_t w);
    while (!no_idle && $urandom_range(99) < 24) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= w;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  task automatic write_reg(reg_idx_e idx, logic [31:0] value);
    logic [31:0] mask;
    case (idx)
      REG_MAGIC:    mask = 32'hFFFF_FFFF;
      REG_VERSION:  mask = 32'h0000_FFFF;
      REG_MAX_ROWS: mask = 32'h0000_FFFF;
      REG_BUDGET:   mask = 32'h0000_00FF;
    endcase
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.set_reg(idx, value);
    // read back through the same select
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== (value & mask)) begin
      sb.errors++;
      $display("%0t: prdata of register %0d expected %0h actual %0h",
               $time, idx, value & mask, prdata);
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.due_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic configure(logic [31:0] magic, logic [15:0] version, logic [15:0] max_rows,
                           logic [7:0] budget);
    drain();
    write_reg(REG_MAGIC, magic);
    write_reg(REG_VERSION, {16'd0, version});
    write_reg(REG_MAX_ROWS, {16'd0, max_rows});
    write_reg(REG_BUDGET, {24'd0, budget});
  endtask

  function automatic word_in_t noise_frame();
    word_in_t w;
    w.pad      = '0;
    w.crc_good = 1'($urandom);
    w.applied  = 1'($urandom);
    w.nack     = 1'($urandom);
    w.ack_ok   = 1'($urandom);
    w.ack_seq  = 16'($urandom);
    w.seq      = $urandom;
    w.rows     = 16'($urandom);
    w.version  = 16'($urandom);
    w.magic    = $urandom;
    w.cmd_rows = 16'($urandom);
    return w;
  endfunction

  function automatic word_in_t good_frame();
    word_in_t w;
    w = '0;
    w.magic    = sb.magic;
    w.version  = sb.version;
    if (sb.lock_rows != 0) w.rows = sb.lock_rows;
    else if (sb.max_rows != 0) w.rows = 16'($urandom_range(sb.max_rows, 1));
    else w.rows = 16'd1;
    w.seq      = sb.prev_seq + 32'd1;
    w.ack_seq  = sb.cmd_cnt;
    w.crc_good = 1'b1;
    w.cmd_rows = 16'($urandom);
    return w;
  endfunction

  function automatic word_in_t random_frame();
    word_in_t    w;
    int unsigned pick;
    w = good_frame();
    pick = $urandom_range(99);
    if (pick < 45) w.seq = sb.prev_seq + 32'd1;
    else if (pick < 60) w.seq = sb.prev_seq;
    else if (pick < 80) w.seq = sb.prev_seq + $urandom_range(20, 2);
    else if (pick < 88) w.seq = sb.prev_seq - $urandom_range(50, 1);
    else if (pick < 91) w.seq = sb.prev_seq + 32'h8000_0000;
    else if (pick < 94) w.seq = sb.prev_seq + 32'h7FFF_FFFF;
    else w.seq = $urandom;
    pick = $urandom_range(99);
    if (pick >= 80) w.ack_seq = 16'($urandom);
    else if (pick >= 60) w.ack_seq = sb.cmd_cnt - 16'd1;
    w.ack_ok = ($urandom_range(2) == 0);
    w.nack   = ($urandom_range(2) == 0);
    if (sb.max_rows != 0 && (sb.lock_rows > sb.max_rows || $urandom_range(9) == 0)) begin
      w.rows    = 16'($urandom_range(sb.max_rows, 1));
      w.applied = 1'b1;
    end else begin
      w.applied = ($urandom_range(19) == 0);
    end
    w.crc_good = ($urandom_range(19) != 0);
    if ($urandom_range(99) < 15) begin
      case ($urandom_range(6))
        0: w.magic = w.magic ^ (32'd1 << $urandom_range(31));
        1: w.magic = $urandom;
        2: w.version = w.version ^ (16'd1 << $urandom_range(15));
        3: w.rows = 16'd0;
        4: begin
          if (sb.max_rows != 16'hFFFF)
            w.rows = 16'($urandom_range(32'hFFFF, 32'(sb.max_rows) + 1));
          else
            w.rows = 16'd0;
        end
        5: begin
          if (sb.lock_rows != 0) begin
            w.rows    = sb.lock_rows + 16'd1;
            w.applied = 1'b0;
          end else begin
            w.crc_good = 1'b0;
          end
        end
        default: w.crc_good = 1'b0;
      endcase
    end
    return w;
  endfunction

  task automatic send_cmd(logic [15:0] rows);
    word_in_t w;
    w = noise_frame();
    w.cmd_rows = rows;
    push_word(KIND_CMD, w);
  endtask

  task automatic random_word();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 8) begin
      pick = $urandom_range(9);
      if (pick == 0) send_cmd(16'd0);
      else if (pick == 1 || sb.max_rows == 0) send_cmd(16'($urandom));
      else send_cmd(16'($urandom_range(sb.max_rows, 1)));
    end else if (pick < 18) begin
      push_word(KIND_FRAME, noise_frame());
    end else begin
      push_word(KIND_FRAME, random_frame());
    end
  endtask

  task automatic run_phase(logic [31:0] magic, logic [15:0] version, logic [15:0] max_rows,
                           logic [7:0] budget, int unsigned count, bit quiet);
    configure(magic, version, max_rows, budget);
    no_idle = quiet;
    repeat (count) random_word();
  endtask

  initial begin : stimulus
    word_in_t w;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // first frame, duplicate, next, forward gap across the wrap
    w = good_frame();
    w.seq = 32'hFFFF_FFF0;
    w.rows = 16'd64;
    push_word(KIND_FRAME, w);
    push_word(KIND_FRAME, w);
    push_word(KIND_FRAME, good_frame());
    w = good_frame();
    w.seq = 32'd5;
    push_word(KIND_FRAME, w);
    // header checks
    w = good_frame();
    w.magic = ~sb.magic;
    push_word(KIND_FRAME, w);
    w = good_frame();
    w.version = 16'hFFFF;
    push_word(KIND_FRAME, w);
    w = good_frame();
    w.rows = 16'd0;
    push_word(KIND_FRAME, w);
    w = good_frame();
    w.rows = 16'd65;
    w.applied = 1'b1;
    push_word(KIND_FRAME, w);
    w = good_frame();
    w.crc_good = 1'b0;
    push_word(KIND_FRAME, w);
    // ack with both bits set locks the size
    send_cmd(16'd16);
    w = good_frame();
    w.ack_ok = 1'b1;
    w.nack = 1'b1;
    push_word(KIND_FRAME, w);
    w = good_frame();
    w.rows = 16'd64;
    push_word(KIND_FRAME, w);
    w.seq = sb.prev_seq + 32'd1;
    w.applied = 1'b1;
    push_word(KIND_FRAME, w);
    // nack, then a zero size acked releases the lock
    send_cmd(16'd0);
    w = good_frame();
    w.nack = 1'b1;
    push_word(KIND_FRAME, w);
    send_cmd(16'd0);
    w = good_frame();
    w.ack_ok = 1'b1;
    push_word(KIND_FRAME, w);
    // half-range step, largest gap, small step back
    w = good_frame();
    w.seq = sb.prev_seq + 32'h8000_0000;
    push_word(KIND_FRAME, w);
    w = good_frame();
    w.seq = sb.prev_seq + 32'h7FFF_FFFF;
    push_word(KIND_FRAME, w);
    w = good_frame();
    w.seq = sb.prev_seq - 32'd3;
    push_word(KIND_FRAME, w);
    // matching ack without bits, then a new command replaces the busy one
    send_cmd(16'd32);
    push_word(KIND_FRAME, good_frame());
    send_cmd(16'd8);
    w = good_frame();
    w.ack_seq = sb.cmd_cnt + 16'd1;
    push_word(KIND_FRAME, w);
    // zero budget: a rejected frame keeps it, a good mismatch gives up
    drain();
    write_reg(REG_BUDGET, 32'd0);
    send_cmd(16'd5);
    w = good_frame();
    w.ack_seq = sb.cmd_cnt + 16'd1;
    w.crc_good = 1'b0;
    push_word(KIND_FRAME, w);
    w = good_frame();
    w.ack_seq = sb.cmd_cnt + 16'd1;
    push_word(KIND_FRAME, w);

    run_phase(MAGIC_RST, VERSION_RST, MAX_ROWS_RST, BUDGET_RST, 240, 1'b0);
    run_phase($urandom, 16'($urandom), 16'hFFFF, 8'hFF, 260, 1'b1);
    run_phase(32'hFFFF_FFFF, 16'hFFFF, 16'd1, 8'd0, 150, 1'b0);
    run_phase($urandom, 16'($urandom), 16'd0, 8'd1, 40, 1'b0);
    run_phase($urandom, 16'($urandom), 16'($urandom_range(300, 2)),
              8'($urandom_range(8)), 300, 1'b0);
    run_phase(32'h0, 16'h0, 16'd64, 8'd3, 250, 1'b0);

    // short budget
    run_phase(32'h0, 16'h0, 16'd64, 8'd2, 30, 1'b0);

    drain();
    if (sb.errors == 0) begin
      $display("frame_ack_sequence_tracker_tb OK");
    end else begin
      $display("frame_ack_sequence_tracker_tb NOT OK");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
src/fast_pkg.sv
src/fast_front.sv
src/fast_queue.sv
src/fast_back.sv
src/frame_ack_sequence_tracker.sv
tb/frame_ack_sequence_tracker_tb.sv
